/* hdl/lpcld_pkg.sv */
// ----------------------------------------------------------------------------
// lpcld_pkg
// Shared constants, types and helpers of the Levinson-Durbin LPC block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcld_pkg;

    // Sizes
    localparam int ORDER_MAX = 16;
    localparam int DEPTH     = ORDER_MAX + 1;
    localparam int IDX_W     = 5;
    localparam int COEF_W    = 32;
    localparam int ACC_W     = 50;   // correlation sum, 8 fraction bits
    localparam int ERR_W     = 40;   // prediction error, 8 fraction bits
    localparam int DIV_STEPS = 30;   // fraction bits of a reflection coefficient
    localparam int RES_W     = 31;

    // Fixed-point ones
    localparam logic signed [COEF_W-1:0] A_ONE = 32'sh0800_0000;  // Q4.27
    localparam logic signed [COEF_W-1:0] K_ONE = 32'sh4000_0000;  // Q1.30
    localparam logic signed [COEF_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] C_MIN = 32'sh8000_0000;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_ZERO      = 2'd1,
        STAT_VANISHED  = 2'd2,
        STAT_SATURATED = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_START,
        ST_CHECK,
        ST_ORD_RD,
        ST_ORD_INIT,
        ST_SUM_RD,
        ST_SUM_MUL,
        ST_SUM_ACC,
        ST_DIV_CHK,
        ST_DIV_FIRST,
        ST_DIV_STEP,
        ST_K_FORM,
        ST_K_STORE,
        ST_UPD_RD1,
        ST_UPD_RD2,
        ST_UPD_MUL1,
        ST_UPD_MUL2,
        ST_UPD_WR2,
        ST_FIN,
        ST_F,
        ST_E1,
        ST_E2,
        ST_E3,
        ST_E_CHK,
        ST_OUT_RD,
        ST_OUT_SHOW
    } state_t;

    // Magnitude of a signed word; the most negative value maps to 2^31
    function automatic logic [COEF_W-1:0] mag32(input logic signed [COEF_W-1:0] x);
        logic [COEF_W-1:0] r;
        r = x[COEF_W-1] ? (~x + 1'b1) : x;
        return r;
    endfunction

    // Clamp a 36-bit sum into a coefficient word
    function automatic logic signed [COEF_W-1:0] sat36(input logic signed [35:0] x);
        logic signed [COEF_W-1:0] r;
        if (x > 36'sh0_7FFF_FFFF) begin
            r = C_MAX;
        end else if (x < -36'sh0_8000_0000) begin
            r = C_MIN;
        end else begin
            r = x[COEF_W-1:0];
        end
        return r;
    endfunction

    function automatic logic ovf36(input logic signed [35:0] x);
        return (x > 36'sh0_7FFF_FFFF) || (x < -36'sh0_8000_0000);
    endfunction

endpackage

`default_nettype wire

/* hdl/lpc_levinson_durbin.sv */
// ----------------------------------------------------------------------------
// lpc_levinson_durbin
// Loads r[0..p], runs the Levinson-Durbin recursion on one shared 32x32
// multiplier and a bit-serial divider, then streams p+1 coefficient results.
// ----------------------------------------------------------------------------
// After the last of p+1 values the recursion runs order by order; the divider
//   gives one quotient bit a cycle, and zero energy skips the recursion.
// Frames are taken one at a time; each result can be held by m_tready.
// Loading takes one value per cycle; s_tready is low from the last load until
// the final result transfers. Reset (aresetn low, synchronous) sets order 16.
`default_nettype none

module lpc_levinson_durbin (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: order
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [4:0]   cfg_data,
    // autocorrelation input
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] autocorr
    // coefficient results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // [4:0] coef_index, [36:5] lpc_coef,
                                         // [68:37] refl_coef, [99:69] residual_error
    output logic [1:0]        m_tuser,   // [1:0] status
    output logic              m_tlast
);

    localparam int IW = lpcld_pkg::IDX_W;
    localparam int CW = lpcld_pkg::COEF_W;
    localparam int AW = lpcld_pkg::ACC_W;
    localparam int EW = lpcld_pkg::ERR_W;

    // Stores
    logic signed [CW-1:0] ac_mem [lpcld_pkg::DEPTH];
    logic signed [CW-1:0] a_mem  [lpcld_pkg::DEPTH];
    logic signed [CW-1:0] k_mem  [lpcld_pkg::DEPTH];

    lpcld_pkg::state_t state_reg, state_next;

    logic [4:0]           order_reg;
    logic [IW-1:0]        load_cnt_reg, load_cnt_next;
    logic [IW-1:0]        p_reg, p_next;
    logic [IW-1:0]        m_reg, m_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [IW-1:0]        o_reg, o_next;
    logic [IW-1:0]        vm_reg, vm_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [EW-1:0]        e_reg, e_next;
    logic [EW-1:0]        rem_reg, rem_next;
    logic [30:0]          q_reg, q_next;
    logic [30:0]          f_reg, f_next;
    logic signed [CW-1:0] k_reg, k_next;
    logic signed [CW-1:0] ai_reg, ai_next;
    logic signed [CW-1:0] aj_reg, aj_next;
    logic                 negk_reg, negk_next;
    logic                 sat_reg, sat_next;
    logic                 van_reg, van_next;
    logic                 zero_reg, zero_next;
    logic [63:0]          prod_reg, plo_reg, plo_next;
    logic                 mneg_reg;

    // Read ports, registered
    logic [IW-1:0]        ac_raddr, a_raddr, k_raddr;
    logic signed [CW-1:0] ac_rd_reg, a_rd_reg, k_rd_reg;

    // Write ports
    logic                 ac_we, a_we, k_we;
    logic [IW-1:0]        ac_waddr, a_waddr, k_waddr;
    logic signed [CW-1:0] ac_wdata, a_wdata, k_wdata;

    // Shared multiplier operands
    logic [CW-1:0]        mul_a, mul_b;
    logic                 mul_neg;

    // Datapath helpers
    logic [IW-1:0]        p_eff;
    logic [AW-1:0]        acc_mag;
    logic [EW:0]          div_t, div_sub;
    logic signed [35:0]   upd_term, upd_sum_i, upd_sum_j, f_s;
    logic [71:0]          e_prod;
    logic [CW-1:0]        k_mag;

    assign cfg_ready = 1'b1;

    // Order register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            order_reg <= cfg_data;
        end
    end

    // Memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (ac_we) ac_mem[ac_waddr] <= ac_wdata;
        if (a_we)  a_mem[a_waddr]   <= a_wdata;
        if (k_we)  k_mem[k_waddr]   <= k_wdata;
        ac_rd_reg <= ac_mem[ac_raddr];
        a_rd_reg  <= a_mem[a_raddr];
        k_rd_reg  <= k_mem[k_raddr];
    end

    // Shared multiplier, product registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        mneg_reg <= mul_neg;
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lpcld_pkg::ST_LOAD;
            load_cnt_reg <= '0;
            p_reg        <= '0;
            m_reg        <= '0;
            i_reg        <= '0;
            o_reg        <= '0;
            vm_reg       <= '0;
            cnt_reg      <= '0;
            negk_reg     <= 1'b0;
            sat_reg      <= 1'b0;
            van_reg      <= 1'b0;
            zero_reg     <= 1'b0;
            e_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            p_reg        <= p_next;
            m_reg        <= m_next;
            i_reg        <= i_next;
            o_reg        <= o_next;
            vm_reg       <= vm_next;
            cnt_reg      <= cnt_next;
            negk_reg     <= negk_next;
            sat_reg      <= sat_next;
            van_reg      <= van_next;
            zero_reg     <= zero_next;
            e_reg        <= e_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        f_reg   <= f_next;
        k_reg   <= k_next;
        ai_reg  <= ai_next;
        aj_reg  <= aj_next;
        plo_reg <= plo_next;
    end

    // Clamp the configured order
    always_comb begin
        if (order_reg == 5'd0) begin
            p_eff = 5'd1;
        end else if (order_reg > 5'(lpcld_pkg::ORDER_MAX)) begin
            p_eff = 5'(lpcld_pkg::ORDER_MAX);
        end else begin
            p_eff = order_reg;
        end
    end

    // Datapath terms
    always_comb begin
        acc_mag   = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        div_t     = {rem_reg, 1'b0};
        div_sub   = div_t - {1'b0, e_reg};
        upd_term  = mneg_reg ? -$signed({2'b00, prod_reg[63:30]})
                             :  $signed({2'b00, prod_reg[63:30]});
        upd_sum_i = 36'(ai_reg) + upd_term;
        upd_sum_j = 36'(aj_reg) + upd_term;
        f_s       = 36'sh0_4000_0000 - $signed({2'b00, prod_reg[63:30]});
        e_prod    = {8'd0, plo_reg} + {prod_reg[39:0], 32'd0};
        k_mag     = lpcld_pkg::mag32(k_reg);
    end

    // Next state and outputs
    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        p_next        = p_reg;
        m_next        = m_reg;
        i_next        = i_reg;
        o_next        = o_reg;
        vm_next       = vm_reg;
        cnt_next      = cnt_reg;
        negk_next     = negk_reg;
        sat_next      = sat_reg;
        van_next      = van_reg;
        zero_next     = zero_reg;
        e_next        = e_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        f_next        = f_reg;
        k_next        = k_reg;
        ai_next       = ai_reg;
        aj_next       = aj_reg;
        plo_next      = plo_reg;
        ac_raddr      = '0;
        a_raddr       = '0;
        k_raddr       = '0;
        ac_we         = 1'b0;
        a_we          = 1'b0;
        k_we          = 1'b0;
        ac_waddr      = load_cnt_reg;
        a_waddr       = i_reg;
        k_waddr       = m_reg;
        ac_wdata      = $signed(s_tdata);
        a_wdata       = lpcld_pkg::sat36(upd_sum_i);
        k_wdata       = k_reg;
        mul_a         = '0;
        mul_b         = '0;
        mul_neg       = 1'b0;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;

        case (state_reg)
            // Take one value per transfer
            lpcld_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ac_we = 1'b1;
                    if (load_cnt_reg >= p_eff) begin
                        load_cnt_next = '0;
                        p_next        = p_eff;
                        state_next    = lpcld_pkg::ST_START;
                    end else begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            lpcld_pkg::ST_START: begin
                state_next = lpcld_pkg::ST_CHECK;
            end
            // Test the energy and seed the error
            lpcld_pkg::ST_CHECK: begin
                sat_next = 1'b0;
                van_next = 1'b0;
                o_next   = '0;
                if (ac_rd_reg <= 0) begin
                    zero_next  = 1'b1;
                    e_next     = '0;
                    state_next = lpcld_pkg::ST_OUT_RD;
                end else begin
                    zero_next  = 1'b0;
                    e_next     = {1'b0, ac_rd_reg[30:0], 8'd0};
                    m_next     = 5'd1;
                    state_next = lpcld_pkg::ST_ORD_RD;
                end
            end
            lpcld_pkg::ST_ORD_RD: begin
                ac_raddr   = m_reg;
                state_next = lpcld_pkg::ST_ORD_INIT;
            end
            lpcld_pkg::ST_ORD_INIT: begin
                acc_next   = {{10{ac_rd_reg[CW-1]}}, ac_rd_reg, 8'd0};
                i_next     = 5'd1;
                state_next = (m_reg == 5'd1) ? lpcld_pkg::ST_DIV_CHK : lpcld_pkg::ST_SUM_RD;
            end
            // Correlation sum, one product per pass
            lpcld_pkg::ST_SUM_RD: begin
                a_raddr    = i_reg;
                ac_raddr   = m_reg - i_reg;
                state_next = lpcld_pkg::ST_SUM_MUL;
            end
            lpcld_pkg::ST_SUM_MUL: begin
                mul_a      = lpcld_pkg::mag32(a_rd_reg);
                mul_b      = lpcld_pkg::mag32(ac_rd_reg);
                mul_neg    = a_rd_reg[CW-1] ^ ac_rd_reg[CW-1];
                state_next = lpcld_pkg::ST_SUM_ACC;
            end
            lpcld_pkg::ST_SUM_ACC: begin
                acc_next = mneg_reg ? acc_reg - $signed({5'd0, prod_reg[63:19]})
                                    : acc_reg + $signed({5'd0, prod_reg[63:19]});
                i_next   = i_reg + 1'b1;
                state_next = (i_reg == m_reg - 1'b1) ? lpcld_pkg::ST_DIV_CHK
                                                     : lpcld_pkg::ST_SUM_RD;
            end
            // Quotient of two or more saturates
            lpcld_pkg::ST_DIV_CHK: begin
                negk_next = !acc_reg[AW-1] && (acc_reg != '0);
                if (acc_mag >= {9'd0, e_reg, 1'b0}) begin
                    if (!acc_reg[AW-1] && (acc_reg != '0)) begin
                        k_next = lpcld_pkg::C_MIN;
                    end else begin
                        k_next   = lpcld_pkg::C_MAX;
                        sat_next = 1'b1;
                    end
                    state_next = lpcld_pkg::ST_K_STORE;
                end else begin
                    state_next = lpcld_pkg::ST_DIV_FIRST;
                end
            end
            lpcld_pkg::ST_DIV_FIRST: begin
                cnt_next = '0;
                if (acc_mag >= {10'd0, e_reg}) begin
                    rem_next = EW'(acc_mag - {10'd0, e_reg});
                    q_next   = 31'd1;
                end else begin
                    rem_next = acc_mag[EW-1:0];
                    q_next   = 31'd0;
                end
                state_next = lpcld_pkg::ST_DIV_STEP;
            end
            // Restoring division, one bit a cycle
            lpcld_pkg::ST_DIV_STEP: begin
                if (!div_sub[EW]) begin
                    rem_next = div_sub[EW-1:0];
                    q_next   = {q_reg[29:0], 1'b1};
                end else begin
                    rem_next = div_t[EW-1:0];
                    q_next   = {q_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(lpcld_pkg::DIV_STEPS - 1)) begin
                    state_next = lpcld_pkg::ST_K_FORM;
                end
            end
            lpcld_pkg::ST_K_FORM: begin
                k_next     = negk_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
                state_next = lpcld_pkg::ST_K_STORE;
            end
            lpcld_pkg::ST_K_STORE: begin
                k_we       = 1'b1;
                i_next     = 5'd1;
                state_next = (m_reg == 5'd1) ? lpcld_pkg::ST_FIN : lpcld_pkg::ST_UPD_RD1;
            end
            // Update coefficient pairs a[i], a[m-i]
            lpcld_pkg::ST_UPD_RD1: begin
                a_raddr    = i_reg;
                state_next = lpcld_pkg::ST_UPD_RD2;
            end
            lpcld_pkg::ST_UPD_RD2: begin
                a_raddr    = m_reg - i_reg;
                ai_next    = a_rd_reg;
                state_next = lpcld_pkg::ST_UPD_MUL1;
            end
            lpcld_pkg::ST_UPD_MUL1: begin
                aj_next    = a_rd_reg;
                mul_a      = k_mag;
                mul_b      = lpcld_pkg::mag32(a_rd_reg);
                mul_neg    = k_reg[CW-1] ^ a_rd_reg[CW-1];
                state_next = lpcld_pkg::ST_UPD_MUL2;
            end
            lpcld_pkg::ST_UPD_MUL2: begin
                a_we    = 1'b1;
                a_waddr = i_reg;
                a_wdata = lpcld_pkg::sat36(upd_sum_i);
                if (lpcld_pkg::ovf36(upd_sum_i)) sat_next = 1'b1;
                mul_a   = k_mag;
                mul_b   = lpcld_pkg::mag32(ai_reg);
                mul_neg = k_reg[CW-1] ^ ai_reg[CW-1];
                if (i_reg == m_reg - i_reg) begin
                    state_next = lpcld_pkg::ST_FIN;
                end else begin
                    state_next = lpcld_pkg::ST_UPD_WR2;
                end
            end
            lpcld_pkg::ST_UPD_WR2: begin
                a_we    = 1'b1;
                a_waddr = m_reg - i_reg;
                a_wdata = lpcld_pkg::sat36(upd_sum_j);
                if (lpcld_pkg::ovf36(upd_sum_j)) sat_next = 1'b1;
                i_next  = i_reg + 1'b1;
                if ({i_reg + 1'b1, 1'b0} <= {1'b0, m_reg}) begin
                    state_next = lpcld_pkg::ST_UPD_RD1;
                end else begin
                    state_next = lpcld_pkg::ST_FIN;
                end
            end
            // New top coefficient, then k*k
            lpcld_pkg::ST_FIN: begin
                a_we       = 1'b1;
                a_waddr    = m_reg;
                a_wdata    = k_reg[CW-1] ? -$signed({3'd0, k_mag[CW-1:3]})
                                         :  $signed({3'd0, k_mag[CW-1:3]});
                mul_a      = k_mag;
                mul_b      = k_mag;
                state_next = lpcld_pkg::ST_F;
            end
            lpcld_pkg::ST_F: begin
                if (f_s <= 0) begin
                    e_next     = '0;
                    state_next = lpcld_pkg::ST_E_CHK;
                end else begin
                    f_next     = f_s[30:0];
                    state_next = lpcld_pkg::ST_E1;
                end
            end
            // Error update in two partial products
            lpcld_pkg::ST_E1: begin
                mul_a      = e_reg[31:0];
                mul_b      = {1'b0, f_reg};
                state_next = lpcld_pkg::ST_E2;
            end
            lpcld_pkg::ST_E2: begin
                plo_next   = prod_reg;
                mul_a      = {24'd0, e_reg[EW-1:32]};
                mul_b      = {1'b0, f_reg};
                state_next = lpcld_pkg::ST_E3;
            end
            lpcld_pkg::ST_E3: begin
                e_next     = e_prod[69:30];
                state_next = lpcld_pkg::ST_E_CHK;
            end
            lpcld_pkg::ST_E_CHK: begin
                o_next = '0;
                if (e_reg == '0) begin
                    van_next   = 1'b1;
                    vm_next    = m_reg;
                    state_next = lpcld_pkg::ST_OUT_RD;
                end else if (m_reg == p_reg) begin
                    state_next = lpcld_pkg::ST_OUT_RD;
                end else begin
                    m_next     = m_reg + 1'b1;
                    state_next = lpcld_pkg::ST_ORD_RD;
                end
            end
            // Stream the results
            lpcld_pkg::ST_OUT_RD: begin
                a_raddr    = o_reg;
                k_raddr    = o_reg;
                state_next = lpcld_pkg::ST_OUT_SHOW;
            end
            lpcld_pkg::ST_OUT_SHOW: begin
                a_raddr  = o_reg;
                k_raddr  = o_reg;
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (o_reg == p_reg) begin
                        o_next     = '0;
                        state_next = lpcld_pkg::ST_LOAD;
                    end else begin
                        o_next     = o_reg + 1'b1;
                        state_next = lpcld_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = lpcld_pkg::ST_LOAD;
            end
        endcase
    end

    // Result payload
    logic signed [CW-1:0] lpc_out, refl_out;
    logic [1:0]           stat_out;

    always_comb begin
        if (zero_reg) begin
            lpc_out  = '0;
            refl_out = '0;
        end else if (o_reg == '0) begin
            lpc_out  = lpcld_pkg::A_ONE;
            refl_out = lpcld_pkg::K_ONE;
        end else if (van_reg && (o_reg >= vm_reg)) begin
            lpc_out  = '0;
            refl_out = '0;
        end else begin
            lpc_out  = a_rd_reg;
            refl_out = k_rd_reg;
        end

        if (zero_reg) begin
            stat_out = lpcld_pkg::STAT_ZERO;
        end else if (sat_reg) begin
            stat_out = lpcld_pkg::STAT_SATURATED;
        end else if (van_reg) begin
            stat_out = lpcld_pkg::STAT_VANISHED;
        end else begin
            stat_out = lpcld_pkg::STAT_OK;
        end
    end

    assign m_tdata = {4'd0, (zero_reg ? 31'd0 : e_reg[38:8]), refl_out, lpc_out, o_reg};
    assign m_tuser = stat_out;
    assign m_tlast = (o_reg == p_reg);

    // Checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[4:0] == p_reg))
        else $error("last result not at the prediction order");

    a_zero_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == lpcld_pkg::STAT_ZERO)) |-> (m_tdata[68:5] == '0))
        else $error("zero energy with nonzero coefficients");

    a_load_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not back to loading after the final result");

endmodule

`default_nettype wire
